[rtl/oldq_pkg.sv]
// Shared types, codes and defaults of the ordered list deque engine.
package oldq_pkg;

  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int STAT_W       = 2;
  localparam int FIELD_CNT_W  = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_DEL_FRONT = 3'd2,
    OP_DEL_BACK  = 3'd3,
    OP_DEL_VALUE = 3'd4,
    OP_SEARCH    = 3'd5
  } op_e_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE     = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } stat_e_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_RES  = 2'd2
  } state_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] item_value;
    logic [FIELD_CNT_W-1:0]   position;
    logic [FIELD_CNT_W-1:0]   entry_count;
  } out_item_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                     cmp;
    logic                     upd;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

[rtl/oldq_cell.sv]
// One list slot: holds an entry, compares it to the broadcast value and shifts.
module oldq_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                              clk,
  input  oldq_pkg::cell_ctl_t               ctl,
  input  logic [CW-1:0]                     count,
  input  logic signed [oldq_pkg::DATA_W-1:0] prev_data,
  input  logic signed [oldq_pkg::DATA_W-1:0] next_data,
  input  logic                              is_last,
  input  logic                              incl_hit,
  output logic signed [oldq_pkg::DATA_W-1:0] data,
  output logic                              match
);
  import oldq_pkg::*;

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     match_r, match_nxt;
  logic                     occupied;

  assign occupied = (CW'(IDX) < count);

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp) begin
      if (ctl.op == OP_DEL_BACK) begin
        match_nxt = occupied && ((CW+1)'(IDX + 1) == {1'b0, count});
      end else begin
        match_nxt = occupied && (data_r == ctl.value);
      end
    end
  end

  always_comb begin
    data_nxt = data_r;
    if (ctl.upd) begin
      case (ctl.op)
        OP_INS_FRONT: data_nxt = (IDX == 0) ? ctl.value : prev_data;
        OP_INS_BACK: begin
          if ((CW+1)'(IDX) == {1'b0, count}) data_nxt = ctl.value;
        end
        OP_DEL_FRONT: begin
          if (!is_last) data_nxt = next_data;
        end
        OP_DEL_VALUE: begin
          if (!is_last && incl_hit) data_nxt = next_data;
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

[rtl/oldq_scan.sv]
// First-match scan over the cell row: prefix OR, position encode, entry select.
module oldq_scan #(
  parameter int N  = 64,
  parameter int CW = 7
) (
  input  logic [N-1:0]                              match,
  input  logic [N-1:0][oldq_pkg::DATA_W-1:0]         cell_data,
  output logic [N-1:0]                              incl_hit,
  output logic                                      found,
  output logic [CW-1:0]                             position,
  output logic [oldq_pkg::DATA_W-1:0]                sel_data
);
  import oldq_pkg::*;

  logic [N-1:0] pre;
  logic [N-1:0] first;

  // Log-depth prefix OR: bit i is set when any cell at or before i matches.
  always_comb begin
    pre = match;
    for (int s = 1; s < N; s = s * 2) begin
      pre = pre | (pre << s);
    end
  end

  assign first    = match & ~(pre << 1);
  assign incl_hit = pre;
  assign found    = pre[N-1];

  always_comb begin
    position = '0;
    sel_data = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i]) begin
        position = position | CW'(i + 1);
        sel_data = sel_data | cell_data[i];
      end
    end
  end

endmodule

[rtl/ordered_list_deque_engine.sv]
// Top level of the ordered list deque engine: sequencer, cell row and result register.
//
//   channel  direction  handshake              beat payload
//   in_      in         in_valid / in_ready    in_data: operation, value
//   out_     out        out_valid / out_ready  out_data: status, item_value, position, count
//
// A beat is handled in turn: the accept cycle latches the beat, the compare cycle has
// every cell check its entry against the value at once (a back delete tags the tail), and
// the result cycle resolves the first match, shifts the row and loads the output register.
// A new beat is taken only once the sequencer is back in idle.
// The result cycle holds while the output register is full and not being taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending result.
module ordered_list_deque_engine #(
  parameter int CAPACITY = oldq_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  oldq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output oldq_pkg::out_item_t out_data
);
  import oldq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  state_t                   state_r, state_nxt;
  logic [OP_W-1:0]          op_r, op_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic        in_fire;
  logic        res_go;
  logic        do_cmp;
  logic        do_upd;
  logic        full, empty;
  cell_ctl_t   ctl;

  logic [CAPACITY-1:0]             match;
  logic [CAPACITY-1:0]             incl_hit;
  logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
  logic                            found;
  logic [CW-1:0]                   position;
  logic [DATA_W-1:0]               sel_data;

  assign in_fire = in_valid && in_ready;
  // Advance out of the result cycle only when the output register can take the beat.
  assign res_go  = (state_r == S_RES) && (!out_valid_r || out_ready);
  assign full    = (count_r == CW'(CAPACITY));
  assign empty   = (count_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_RES;
      S_RES:  if (res_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready = 1'b0;
    do_cmp   = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_CMP:  do_cmp   = 1'b1;
      S_RES:  ;
      default: ;
    endcase
  end

  // Latch the operation on accept, hold it through compare and result.
  always_comb begin
    op_nxt  = op_r;
    val_nxt = val_r;
    if (in_fire) begin
      op_nxt  = in_data.operation;
      val_nxt = in_data.value;
    end
  end

  // Resolve the result and decide whether the row is written.
  always_comb begin
    do_upd                   = 1'b0;
    count_nxt                = count_r;
    out_data_nxt             = out_data_r;
    out_valid_nxt            = out_valid_r && !out_ready;
    if (res_go) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.status      = STAT_DONE;
      out_data_nxt.item_value  = '0;
      out_data_nxt.position    = '0;
      case (op_r) inside
        OP_INS_FRONT, OP_INS_BACK: begin
          if (full) begin
            out_data_nxt.status = STAT_FULL;
          end else begin
            do_upd    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_DEL_FRONT, OP_DEL_BACK: begin
          if (empty) begin
            out_data_nxt.status = STAT_EMPTY;
          end else begin
            do_upd    = 1'b1;
            count_nxt = count_r - CW'(1);
            // Front entry sits in cell zero; the tail was tagged during compare.
            out_data_nxt.item_value = (op_r == OP_DEL_FRONT) ? cell_data[0] : sel_data;
          end
        end
        OP_DEL_VALUE: begin
          if (!found) begin
            out_data_nxt.status = STAT_NOTFOUND;
          end else begin
            do_upd                  = 1'b1;
            count_nxt               = count_r - CW'(1);
            out_data_nxt.item_value = val_r;
          end
        end
        OP_SEARCH: begin
          if (!found) begin
            out_data_nxt.status = STAT_NOTFOUND;
          end else begin
            out_data_nxt.item_value = val_r;
            out_data_nxt.position   = FIELD_CNT_W'(position);
          end
        end
        default: ;
      endcase
      out_data_nxt.entry_count = FIELD_CNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Broadcast to the row.
  assign ctl.cmp   = do_cmp;
  assign ctl.upd   = do_upd;
  assign ctl.op    = op_r;
  assign ctl.value = val_r;

  // Cell row: each cell sees its neighbors; the ends see themselves.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] prev_d, next_d;
    logic signed [DATA_W-1:0] own_d;

    if (g == 0) begin : g_head
      assign prev_d = own_d;
    end else begin : g_mid_p
      assign prev_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign next_d = own_d;
    end else begin : g_mid_n
      assign next_d = cell_data[g+1];
    end

    oldq_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .prev_data (prev_d),
      .next_data (next_d),
      .is_last   (g == CAPACITY - 1),
      .incl_hit  (incl_hit[g]),
      .data      (own_d),
      .match     (match[g])
    );

    assign cell_data[g] = own_d;
  end

  oldq_scan #(
    .N  (CAPACITY),
    .CW (CW)
  ) u_scan (
    .match     (match),
    .cell_data (cell_data),
    .incl_hit  (incl_hit),
    .found     (found),
    .position  (position),
    .sel_data  (sel_data)
  );

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // After an accept the input side closes until the result is out.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second beat accepted while one is in flight");

  // The count only moves on the result cycle that hands a beat to the output.
  a_count_moves_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |-> $past(res_go))
    else $error("entry count changed outside a result cycle");

  // A result beat appears only from a completed result cycle.
  a_out_from_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(res_go))
    else $error("result beat raised without a result cycle");

endmodule
